// File: sv/conv3x3_stream_top_assert.svh
// Assertion shorthands used by the streaming convolution top, conv3x3_stream_top.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef CONV3X3_STREAM_TOP_ASSERT_SVH
`define CONV3X3_STREAM_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CONV3S_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CONV3S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/conv3s_pkg.sv
package conv3s_pkg;

    // Default sizes of the block.
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT_DEF    = 4096;
    localparam int PIXEL_BITS_DEF    = 16;
    localparam int TAPS_PER_SIDE_DEF = 3;

    // Coefficients are signed Q4.12.
    localparam int COEF_BITS = 16;
    localparam int COEF_FRAC = 12;
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC);

    // Configuration register file.
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 48;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;

    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = CFG_WIDTH_BITS'(640);
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = CFG_HEIGHT_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_KERNEL_TOP   = 3'd2,
        REG_KERNEL_MID   = 3'd3,
        REG_KERNEL_BOT   = 3'd4
    } cfg_reg_t;

    // Enables that step one window cell.
    typedef struct packed {
        logic load;   // take a new column and form its products
        logic sum;    // add the column's products
    } cell_ctrl_t;

endpackage

// File: sv/conv3s_if.sv
// Input channel: one pixel per item.
interface conv3s_pix_if #(
    parameter int PIXEL_BITS = conv3s_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// Output channel: one filtered centre per item.
interface conv3s_res_if #(
    parameter int FILT_BITS = 36,
    parameter int ROW_BITS  = 12,
    parameter int COL_BITS  = 10
);
    logic                        valid;
    logic                        ready;
    logic signed [FILT_BITS-1:0] filtered;
    logic [ROW_BITS-1:0]         out_row;
    logic [COL_BITS-1:0]         out_col;
    logic                        frame_last;

    modport source (output valid, output filtered, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input filtered, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

// File: sv/conv3s_cell.sv
// One column of the 3x3 window. It holds the column it was last given and
// hands it on to its left neighbour, multiplies the incoming column by its
// own column of coefficients and adds the products one stage later.
module conv3s_cell #(
    parameter int TAPS       = conv3s_pkg::TAPS_PER_SIDE_DEF,
    parameter int PIXEL_BITS = conv3s_pkg::PIXEL_BITS_DEF
) (
    input  logic                                                clk,
    input  conv3s_pkg::cell_ctrl_t                              ctrl,
    input  logic signed [conv3s_pkg::COEF_BITS-1:0]             coef    [TAPS],
    input  logic signed [PIXEL_BITS-1:0]                        col_in  [TAPS],
    output logic signed [PIXEL_BITS-1:0]                        col_out [TAPS],
    output logic signed [PIXEL_BITS+conv3s_pkg::COEF_BITS+$clog2(TAPS)-1:0] col_sum
);
    import conv3s_pkg::*;

    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + $clog2(TAPS);

    logic signed [PIXEL_BITS-1:0] tap_reg  [TAPS];
    logic signed [PROD_BITS-1:0]  prod_reg [TAPS];
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic signed [SUM_BITS-1:0]   sum_next;

    // Held column and products of the incoming column.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tap_reg[i]  <= col_in[i];
                prod_reg[i] <= PROD_BITS'(col_in[i]) * PROD_BITS'(coef[i]);
            end
        end
    end

    // Column sum of the registered products.
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            sum_next = sum_next + SUM_BITS'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = tap_reg;
    assign col_sum = sum_reg;

endmodule

// File: sv/conv3s_lstore.sv
// Line store: one write port and one read port with registered read data.
// The read register holds its value while no read is requested.
module conv3s_lstore #(
    parameter int DEPTH     = conv3s_pkg::MAX_WIDTH_DEF,
    parameter int WORD_BITS = conv3s_pkg::PIXEL_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WORD_BITS-1:0]       rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WORD_BITS-1:0]       wr_data
);
    import conv3s_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/conv3x3_stream_top.sv
// Streaming 3x3 convolution over signed pixels in raster order. It takes one
// pixel per clock unless results.ready stalls it and, once the window is full,
// gives one result per interior pixel in the same order, after stages 1 to 3
// and the output register; border centres give no result and the last interior
// result of a frame carries frame_last. The rate is set by the line stores,
// which are read once and written once per pixel, and by the three window cells,
// which step by one column per pixel. The line stores are not cleared after
// reset; no result depends on an entry not written earlier in the frame. The
// results are exact: the full sum with 12 fraction bits.
`include "conv3x3_stream_top_assert.svh"

module conv3x3_stream_top #(
    parameter int MAX_WIDTH     = conv3s_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = conv3s_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS    = conv3s_pkg::PIXEL_BITS_DEF,
    parameter int TAPS_PER_SIDE = conv3s_pkg::TAPS_PER_SIDE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [conv3s_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [conv3s_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    conv3s_pix_if.sink                             pixels,
    conv3s_res_if.source                           results
);
    import conv3s_pkg::*;

    localparam int TAPS      = TAPS_PER_SIDE;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int CW_BITS   = COL_BITS + 1;
    localparam int CH_BITS   = ROW_BITS + 1;
    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int CSUM_BITS = PROD_BITS + $clog2(TAPS);
    localparam int FILT_BITS = PROD_BITS + $clog2(TAPS * TAPS);
    localparam int KROW_BITS = TAPS * COEF_BITS;
    localparam int NSTORE    = TAPS - 1;
    localparam int CENTRE    = TAPS / 2;
    localparam int LEAD      = TAPS - 1;

    localparam logic [KROW_BITS-1:0] KMID_RESET =
        KROW_BITS'(COEF_ONE) << (COEF_BITS * CENTRE);

    // Bookkeeping that travels with each item.
    typedef struct packed {
        logic                emit;
        logic                last;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [COL_BITS-1:0] addr;
    } meta_t;

    logic [CFG_WIDTH_BITS-1:0]  width_reg;
    logic [CFG_HEIGHT_BITS-1:0] height_reg;
    logic [KROW_BITS-1:0]       kernel_reg [TAPS];

    logic [CW_BITS-1:0] cw;
    logic [CH_BITS-1:0] ch;

    logic [COL_BITS-1:0] col_cnt_reg;
    logic [ROW_BITS-1:0] row_cnt_reg;
    logic                col_end;
    logic                row_end;
    logic                accept;
    meta_t               meta_in;

    logic                         s1_v_reg;
    meta_t                        s1_meta_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg;
    logic                         s1_move;

    logic                         s2_v_reg;
    meta_t                        s2_meta_reg;
    logic                         s3_v_reg;
    meta_t                        s3_meta_reg;

    logic                         out_v_reg;
    logic signed [FILT_BITS-1:0]  out_filt_reg;
    logic signed [FILT_BITS-1:0]  filt_next;
    meta_t                        out_meta_reg;

    logic free1;
    logic free2;
    logic free3;
    logic free_out;

    logic [PIXEL_BITS-1:0]        store_rd [NSTORE];
    logic signed [PIXEL_BITS-1:0] col_new  [TAPS];
    logic signed [PIXEL_BITS-1:0] chain    [TAPS-1][TAPS];
    logic signed [COEF_BITS-1:0]  coef_col [TAPS][TAPS];
    logic signed [CSUM_BITS-1:0]  csum     [TAPS];
    cell_ctrl_t                   cell_ctrl;

    logic                rd_en;
    logic [COL_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_addr;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            for (int j = 0; j < TAPS; j++)
            begin
                kernel_reg[j] <= (j == CENTRE) ? KMID_RESET : '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[CFG_WIDTH_BITS-1:0];
            end
            else if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
            end
            for (int j = 0; j < TAPS; j++)
            begin
                if (cfg_index == CFG_IDX_BITS'(int'(REG_KERNEL_TOP) + j))
                begin
                    kernel_reg[j] <= cfg_data[KROW_BITS-1:0];
                end
            end
        end
    end

    // Frame size in use, held to the supported range.
    always_comb
    begin
        if (32'(width_reg) < 32'(TAPS))
        begin
            cw = CW_BITS'(TAPS);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            cw = CW_BITS'(MAX_WIDTH);
        end
        else
        begin
            cw = CW_BITS'(width_reg);
        end

        if (32'(height_reg) < 32'(TAPS))
        begin
            ch = CH_BITS'(TAPS);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            ch = CH_BITS'(MAX_HEIGHT);
        end
        else
        begin
            ch = CH_BITS'(height_reg);
        end
    end

    // Flow control: a stage can take an item when it is empty or moves on.
    assign free_out = !out_v_reg || results.ready;
    assign free3    = !s3_v_reg || free_out;
    assign free2    = !s2_v_reg || free3;
    assign free1    = !s1_v_reg || free2;
    assign accept   = pixels.valid && free1;
    assign s1_move  = s1_v_reg && free2;

    // Position of the incoming item.
    assign col_end = {1'b0, col_cnt_reg} >= cw - CW_BITS'(1);
    assign row_end = {1'b0, row_cnt_reg} >= ch - CH_BITS'(1);

    always_comb
    begin
        meta_in.emit = (col_cnt_reg >= COL_BITS'(LEAD)) && (row_cnt_reg >= ROW_BITS'(LEAD));
        meta_in.last = col_end && row_end;
        meta_in.row  = row_cnt_reg - ROW_BITS'(CENTRE);
        meta_in.col  = col_cnt_reg - COL_BITS'(CENTRE);
        meta_in.addr = col_cnt_reg;
    end

    // Column and row counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_end ? '0 : row_cnt_reg + ROW_BITS'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + COL_BITS'(1);
            end
        end
    end

    // Stage 1: pixel taken, line stores read at its column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (free1)
        begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta_in;
            s1_pix_reg  <= pixels.pixel;
        end
    end

    assign rd_en   = accept;
    assign rd_addr = col_cnt_reg;
    assign wr_en   = s1_move;
    assign wr_addr = s1_meta_reg.addr;

    // Newest column of the window: older rows from the stores, pixel at the bottom.
    always_comb
    begin
        for (int j = 0; j < NSTORE; j++)
        begin
            col_new[j] = store_rd[j];
        end
        col_new[TAPS-1] = s1_pix_reg;
    end

    // Each store takes the row below it, so the rows move up by one.
    for (genvar j = 0; j < NSTORE; j++)
    begin : g_store
        conv3s_lstore #(
            .DEPTH     (MAX_WIDTH),
            .WORD_BITS (PIXEL_BITS)
        ) u_lstore (
            .clk     (clk),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (store_rd[j]),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (col_new[j+1])
        );
    end

    // Coefficients by window column; row j of the kernel comes from register j.
    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                coef_col[k][j] = kernel_reg[j][k*COEF_BITS +: COEF_BITS];
            end
        end
    end

    assign cell_ctrl.load = s1_move;
    assign cell_ctrl.sum  = s2_v_reg && free3;

    // Window cells: the rightmost takes the new column, each hands its column left.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        if (k == TAPS - 1)
        begin : g_right
            conv3s_cell #(
                .TAPS       (TAPS),
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .coef    (coef_col[k]),
                .col_in  (col_new),
                .col_out (chain[k-1]),
                .col_sum (csum[k])
            );
        end
        else if (k == 0)
        begin : g_left
            conv3s_cell #(
                .TAPS       (TAPS),
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .coef    (coef_col[k]),
                .col_in  (chain[k]),
                .col_out (),
                .col_sum (csum[k])
            );
        end
        else
        begin : g_inner
            conv3s_cell #(
                .TAPS       (TAPS),
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .clk     (clk),
                .ctrl    (cell_ctrl),
                .coef    (coef_col[k]),
                .col_in  (chain[k]),
                .col_out (chain[k-1]),
                .col_sum (csum[k])
            );
        end
    end

    // Stages 2 and 3 carry only items that give a result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (free2)
            begin
                s2_v_reg <= s1_v_reg && s1_meta_reg.emit;
            end
            if (free3)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (cell_ctrl.sum)
        begin
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // Final sum across the column sums.
    always_comb
    begin
        filt_next = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            filt_next = filt_next + FILT_BITS'(csum[k]);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (free_out)
        begin
            out_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_out && s3_v_reg)
        begin
            out_filt_reg <= filt_next;
            out_meta_reg <= s3_meta_reg;
        end
    end

    assign pixels.ready       = free1;
    assign results.valid      = out_v_reg;
    assign results.filtered   = out_filt_reg;
    assign results.out_row    = out_meta_reg.row;
    assign results.out_col    = out_meta_reg.col;
    assign results.frame_last = out_meta_reg.last;

    // Consecutive pixels never share a column, so the store ports never meet.
    `CONV3S_ASSERT_IMPLY(a_store_ports_apart, rd_en && wr_en, rd_addr != wr_addr, "line store read and write at one address")

    // Only interior centres give a result.
    `CONV3S_ASSERT_IMPLY(a_interior_only, results.valid, (results.out_row != '0) && (results.out_col != '0), "result for a border centre")

    // A summed item waits in stage 3 until the output register takes it.
    `CONV3S_ASSERT_NEXT(a_stage3_holds, s3_v_reg && !free_out, s3_v_reg, "item lost from the summing stage")

endmodule

// File: tb/sv/tb_conv3x3_stream_top.sv
module tb_conv3x3_stream_top;
    timeunit 1ns;
    timeprecision 1ps;

    import conv3s_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH_DEF;
    localparam int ROW_DEPTH  = MAX_HEIGHT_DEF;
    localparam int PIX_BITS   = PIXEL_BITS_DEF;
    localparam int FILT_BITS  = 36;
    localparam int ROW_BITS   = 12;
    localparam int COL_BITS   = 10;

    localparam int     RANDOM_ITEMS  = 1500;
    localparam int     GAP_MAX       = 14;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     FILL_WIDTH    = 64;
    localparam int     TALL_HEIGHT   = 64;
    localparam int     BURST_MAX     = 40;
    localparam longint CYCLE_LIMIT   = 3_000_000;

    localparam logic signed [PIX_BITS-1:0]  PIX_MIN  = {1'b1, {(PIX_BITS-1){1'b0}}};
    localparam logic signed [PIX_BITS-1:0]  PIX_MAX  = {1'b0, {(PIX_BITS-1){1'b1}}};
    localparam logic        [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic        [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};

    // One filtered centre as the block should give it.
    typedef struct packed {
        logic signed [FILT_BITS-1:0] filtered;
        logic [ROW_BITS-1:0]         row;
        logic [COL_BITS-1:0]         col;
        logic                        last;
    } centre_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    conv3s_pix_if pix_ch ();
    conv3s_res_if res_ch ();

    conv3x3_stream_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    // Shadow of the block: configuration, line stores, window and counters.
    logic [CFG_WIDTH_BITS-1:0]  cfg_width;
    logic [CFG_HEIGHT_BITS-1:0] cfg_height;
    logic [CFG_DATA_BITS-1:0]   taps_top;
    logic [CFG_DATA_BITS-1:0]   taps_mid;
    logic [CFG_DATA_BITS-1:0]   taps_bot;
    logic signed [PIX_BITS-1:0] line_old [LINE_DEPTH];
    logic signed [PIX_BITS-1:0] line_new [LINE_DEPTH];
    logic signed [PIX_BITS-1:0] win_px [6];
    logic [COL_BITS-1:0]        col_pos;
    logic [ROW_BITS-1:0]        row_pos;

    logic signed [PIX_BITS-1:0] pixel_q [$];
    centre_t                    centre_q [$];

    int unsigned px_taken;
    int unsigned px_seen;
    int unsigned px_gap;
    int unsigned res_taken;
    int unsigned res_seen;
    int unsigned res_stall;
    bit          quiet_phase;
    int          errors;
    longint      cycles;

    function automatic logic signed [COEF_BITS-1:0] tap_of(input logic [CFG_DATA_BITS-1:0] taps,
                                                          input int k);
        return taps[k*COEF_BITS +: COEF_BITS];
    endfunction

    function automatic int unsigned draw_gap();
        return quiet_phase ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic signed [PIX_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return PIX_MIN;
            1: return PIX_MAX;
            2: return '0;
            3: return '1;
            default: return PIX_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_taps();
        logic [CFG_DATA_BITS-1:0] t;
        int k;
        t = '0;
        for (k = 0; k < TAPS_PER_SIDE_DEF; k++)
        begin
            case ($urandom_range(0, 5))
                0: t[k*COEF_BITS +: COEF_BITS] = COEF_MIN;
                1: t[k*COEF_BITS +: COEF_BITS] = COEF_MAX;
                2: t[k*COEF_BITS +: COEF_BITS] = COEF_ONE;
                default: t[k*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom);
            endcase
        end
        return t;
    endfunction

    // Take one pixel into the shadow and queue the centre it completes, if any.
    task automatic advance_window(input logic signed [PIX_BITS-1:0] px);
        int unsigned w;
        int unsigned h;
        logic signed [PIX_BITS-1:0] fresh [3];
        logic [CFG_DATA_BITS-1:0] kr;
        longint acc;
        bit col_end;
        bit row_end;
        centre_t e;
        int k;
        w = (cfg_width < 3) ? 3 : ((cfg_width > LINE_DEPTH) ? LINE_DEPTH : cfg_width);
        h = (cfg_height < 3) ? 3 : ((cfg_height > ROW_DEPTH) ? ROW_DEPTH : cfg_height);
        fresh[0] = line_old[col_pos];
        fresh[1] = line_new[col_pos];
        fresh[2] = px;
        col_end = (int'(col_pos) >= w - 1);
        row_end = (int'(row_pos) >= h - 1);

        if (row_pos >= 2 && col_pos >= 2)
        begin
            acc = 0;
            for (k = 0; k < 3; k++)
            begin
                kr = (k == 0) ? taps_top : ((k == 1) ? taps_mid : taps_bot);
                acc += longint'(win_px[k])     * longint'(tap_of(kr, 0))
                     + longint'(win_px[k + 3]) * longint'(tap_of(kr, 1))
                     + longint'(fresh[k])      * longint'(tap_of(kr, 2));
            end
            e.filtered = acc[FILT_BITS-1:0];
            e.row      = row_pos - 1'b1;
            e.col      = col_pos - 1'b1;
            e.last     = col_end && row_end;
            centre_q.push_back(e);
        end

        for (k = 0; k < 3; k++)
        begin
            win_px[k]     = win_px[k + 3];
            win_px[k + 3] = fresh[k];
        end
        line_old[col_pos] = fresh[1];
        line_new[col_pos] = px;

        if (col_end)
        begin
            col_pos = '0;
            row_pos = row_end ? '0 : row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // Register write; the shadow follows it at once.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = data[CFG_WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: cfg_height = data[CFG_HEIGHT_BITS-1:0];
            REG_KERNEL_TOP:   taps_top   = data;
            REG_KERNEL_MID:   taps_mid   = data;
            REG_KERNEL_BOT:   taps_bot   = data;
            default: ;
        endcase
    endtask

    // Size registers get random junk above their width, which must be ignored.
    task automatic set_size(input int unsigned w, input int unsigned h);
        logic [CFG_DATA_BITS-1:0] d;
        d = {16'($urandom), 32'($urandom)};
        d[CFG_WIDTH_BITS-1:0] = w[CFG_WIDTH_BITS-1:0];
        write_reg(REG_IMAGE_WIDTH, d);
        d = {16'($urandom), 32'($urandom)};
        d[CFG_HEIGHT_BITS-1:0] = h[CFG_HEIGHT_BITS-1:0];
        write_reg(REG_IMAGE_HEIGHT, d);
    endtask

    task automatic set_kernel(input logic [CFG_DATA_BITS-1:0] t,
                              input logic [CFG_DATA_BITS-1:0] m,
                              input logic [CFG_DATA_BITS-1:0] b);
        write_reg(REG_KERNEL_TOP, t);
        write_reg(REG_KERNEL_MID, m);
        write_reg(REG_KERNEL_BOT, b);
    endtask

    task automatic queue_pixels(input int unsigned n);
        repeat (n) pixel_q.push_back(rand_pixel());
    endtask

    // Hold the sender until every expected centre is back, then let the
    // pipeline settle, since trailing border pixels give nothing to wait on.
    task automatic wait_until_idle();
        while (pixel_q.size() != 0 || pix_ch.valid || centre_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Input side: the shadow takes each pixel item at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            advance_window(pix_ch.pixel);
            px_taken++;
        end
    end

    // Input driver: after each accepted item, wait a drawn gap.
    always @(negedge clk)
    begin
        logic nxt_valid;
        logic signed [PIX_BITS-1:0] nxt_pixel;
        nxt_valid = pix_ch.valid;
        nxt_pixel = pix_ch.pixel;
        if (rst_n)
        begin
            if (px_taken != px_seen)
            begin
                px_seen   = px_taken;
                nxt_valid = 1'b0;
                px_gap    = draw_gap();
            end
            if (!nxt_valid)
            begin
                if (px_gap != 0)
                begin
                    px_gap--;
                end
                else if (pixel_q.size() != 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_pixel = pixel_q.pop_front();
                end
            end
        end
        pix_ch.valid <= nxt_valid;
        pix_ch.pixel <= nxt_pixel;
    end

    // Output side: compare each accepted result item with the oldest expectation.
    always @(posedge clk)
    begin
        centre_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            res_taken++;
            if (centre_q.size() == 0)
            begin
                $error("unexpected result: filtered %0d, out_row %0d, out_col %0d",
                       res_ch.filtered, res_ch.out_row, res_ch.out_col);
                errors++;
            end
            else
            begin
                want = centre_q.pop_front();
                if (res_ch.filtered !== want.filtered)
                begin
                    $error("filtered: expected %0d, actual %0d", want.filtered,
                           res_ch.filtered);
                    errors++;
                end
                if (res_ch.out_row !== want.row)
                begin
                    $error("out_row: expected %0d, actual %0d", want.row, res_ch.out_row);
                    errors++;
                end
                if (res_ch.out_col !== want.col)
                begin
                    $error("out_col: expected %0d, actual %0d", want.col, res_ch.out_col);
                    errors++;
                end
                if (res_ch.frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, actual %0d", want.last,
                           res_ch.frame_last);
                    errors++;
                end
            end
        end
    end

    // Output ready: after each accepted item, hold ready low for a drawn stall.
    always @(negedge clk)
    begin
        logic nxt_ready;
        nxt_ready = res_ch.ready;
        if (res_taken != res_seen)
        begin
            res_seen  = res_taken;
            res_stall = draw_gap();
            nxt_ready = (res_stall == 0);
        end
        else if (!nxt_ready)
        begin
            if (res_stall != 0)
                res_stall--;
            if (res_stall == 0)
                nxt_ready = 1'b1;
        end
        res_ch.ready <= nxt_ready;
    end

    // Stimulus.
    initial
    begin
        logic signed [PIX_BITS-1:0] pattern [9];
        int unsigned w;
        int unsigned h;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned n;
        int unsigned random_items;
        bit burst_last;
        int i;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        res_ch.ready = 1'b0;
        px_taken     = 0;
        px_seen      = 0;
        px_gap       = 0;
        res_taken    = 0;
        res_seen     = 0;
        res_stall    = 0;
        quiet_phase  = 1'b0;
        errors       = 0;
        random_items = 0;
        burst_last   = 1'b0;

        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        taps_top   = '0;
        taps_mid   = {{COEF_BITS{1'b0}}, COEF_ONE, {COEF_BITS{1'b0}}};
        taps_bot   = '0;
        foreach (line_old[j])
        begin
            line_old[j] = '0;
            line_new[j] = '0;
        end
        foreach (win_px[j])
            win_px[j] = '0;
        col_pos = '0;
        row_pos = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Smallest frame under the reset kernel, which passes the centre through.
        pattern = '{PIX_MAX, PIX_MIN, '1, '0, PIX_MIN, 16'sd1, PIX_MAX, '1, PIX_MIN};
        set_size(3, 3);
        for (i = 0; i < 9; i++)
            pixel_q.push_back(pattern[i]);
        wait_until_idle();

        // Most negative taps on most negative pixels: the largest sum.
        set_kernel({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}});
        repeat (9) pixel_q.push_back(PIX_MIN);
        wait_until_idle();

        // Largest taps on most negative pixels, with sizes below range clamped to 3.
        set_size(0, 0);
        set_kernel({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}});
        repeat (9) pixel_q.push_back(PIX_MIN);
        wait_until_idle();

        // Two full rows at a wide size write every store entry that a later
        // oversized burst can reach. The frame then stops part-way through the
        // last row and is shrunk, so that the column counter sits past the end.
        set_size(FILL_WIDTH, 3);
        set_kernel(rand_taps(), rand_taps(), rand_taps());
        queue_pixels(2 * FILL_WIDTH + $urandom_range(8, FILL_WIDTH - 8));
        wait_until_idle();
        set_size(5, 4);
        queue_pixels(40);
        wait_until_idle();

        // Tall frame on the narrowest row: the row counter runs well past the window.
        set_size(3, TALL_HEIGHT);
        set_kernel(rand_taps(), rand_taps(), rand_taps());
        queue_pixels(3 * TALL_HEIGHT + 6);
        wait_until_idle();

        // Random phases: small frames, whole or cut short, with random kernels.
        while (random_items < RANDOM_ITEMS)
        begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            if (!burst_last && $urandom_range(0, 15) == 0)
            begin
                // Oversized registers for a short burst; the next phase shrinks
                // the frame again mid-way. Bursts never follow each other, so the
                // columns they reach stay inside the rows written above.
                set_size($urandom_range(LINE_DEPTH + 1, (1 << CFG_WIDTH_BITS) - 1),
                         $urandom_range(ROW_DEPTH + 1, (1 << CFG_HEIGHT_BITS) - 1));
                n = $urandom_range(1, BURST_MAX);
                burst_last = 1'b1;
            end
            else
            begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 8);
                w_eff = (w < 3) ? 3 : w;
                h_eff = (h < 3) ? 3 : h;
                set_size(w, h);
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_KERNEL_TOP, rand_taps());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_KERNEL_MID, rand_taps());
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_KERNEL_BOT, rand_taps());
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_IDX_BITS'($urandom_range(int'(REG_KERNEL_BOT) + 1,
                                                           (1 << CFG_IDX_BITS) - 1)),
                              {16'($urandom), 32'($urandom)});
                if ($urandom_range(0, 1) == 0)
                    n = w_eff * h_eff * $urandom_range(1, 2);
                else
                    n = $urandom_range(1, w_eff * h_eff);
                burst_last = 1'b0;
            end
            queue_pixels(n);
            random_items += n;
            wait_until_idle();
        end

        quiet_phase = 1'b0;
        wait_until_idle();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
